>>> hw/rtl/usvg_pkg.sv
// Shared types, constants and helper functions for the UV sphere vertex generator.
// Depends on nothing; every other file of the block imports it.
package usvg_pkg;

    localparam int MAX_DIVISIONS   = 256;
    localparam int COORD_FRAC_BITS = 14;
    localparam int XY_SHIFT        = 60 - COORD_FRAC_BITS;
    localparam int Z_SHIFT         = 30 - COORD_FRAC_BITS;
    localparam int DIV_STEPS       = 32;
    localparam int TRIG_STEPS      = 6;
    localparam int VERTS_PER_CELL  = 6;

    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [15:0] COORD_ONE = 16'(1 << COORD_FRAC_BITS);

    // Horner coefficients of the sine polynomial, Q30, innermost first.
    localparam logic [30:0] T_INIT = 31'd172272;
    localparam logic [3:0][30:0] HORNER_COEF = {
        31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995
    };

    // Bit k tells which ring (layer) and which azimuth vertex k uses.
    localparam logic [5:0] RING_OF = 6'b110100;
    localparam logic [5:0] DIR_OF  = 6'b010110;
    localparam logic [2:0] LAST_VERT = 3'(VERTS_PER_CELL - 1);

    typedef enum logic [2:0] {
        CFG_SLICE_COUNT,
        CFG_LAYER_COUNT,
        CFG_COLOR_RED,
        CFG_COLOR_GREEN,
        CFG_COLOR_BLUE,
        CFG_COLOR_ALPHA
    } t_cfg_index;

    typedef enum logic [1:0] {
        OP_SQUARE,
        OP_HORNER,
        OP_FINAL
    } t_trig_op;

    // Division chain payload: four phase divisions, one per lane.
    typedef struct packed {
        logic              bad;
        logic [18:0]       base;
        logic [3:0][9:0]   den;
        logic [3:0][9:0]   rem;
        logic [3:0][31:0]  acc;
    } t_div;

    // Sine chain payload: eight sine/cosine evaluations, one per lane.
    // Lanes: 0,1 ring radius; 2,3 z; 4,5 cosine of azimuth; 6,7 sine of azimuth.
    typedef struct packed {
        logic              bad;
        logic [18:0]       base;
        logic [7:0]        neg;
        logic [7:0][30:0]  x;
        logic [7:0][30:0]  x2;
        logic [7:0][30:0]  t;
    } t_trig;

    typedef struct packed {
        logic        neg;
        logic [30:0] x;
    } t_fold;

    // Fold a turn phase into a quarter turn argument and a sign.
    function automatic t_fold f_fold(input logic [31:0] p, input logic use_cos);
        logic [31:0] q;
        t_fold       f;
        q     = use_cos ? (p + 32'h4000_0000) : p;
        f.neg = q[31];
        f.x   = q[30] ? (Q30_ONE - {1'b0, q[29:0]}) : {1'b0, q[29:0]};
        return f;
    endfunction

    // Round half up in magnitude, limit to 1.0, apply the sign.
    function automatic logic [15:0] f_coord_xy(input logic [61:0] p, input logic neg);
        logic [62:0] s;
        logic [62:0] v;
        logic [15:0] m;
        s = {1'b0, p} + (63'd1 << (XY_SHIFT - 1));
        v = s >> XY_SHIFT;
        m = (v > {47'd0, COORD_ONE}) ? COORD_ONE : v[15:0];
        return neg ? (16'd0 - m) : m;
    endfunction

    function automatic logic [15:0] f_coord_z(input logic [30:0] z, input logic neg);
        logic [31:0] s;
        logic [31:0] v;
        logic [15:0] m;
        s = {1'b0, z} + (32'd1 << (Z_SHIFT - 1));
        v = s >> Z_SHIFT;
        m = (v > {16'd0, COORD_ONE}) ? COORD_ONE : v[15:0];
        return neg ? (16'd0 - m) : m;
    endfunction

endpackage

>>> hw/rtl/usvg_div_cell.sv
// One restoring division step for the four phase lanes, registered.
// Depends on usvg_pkg for the t_div payload type.
module usvg_div_cell
    import usvg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_data,
    output logic o_valid,
    output t_div o_data
);

    logic [3:0][10:0] w_trial;
    t_div             n_data;
    logic             r_valid;
    t_div             r_data;

    // Shift the next dividend bit into the remainder and the quotient bit into acc.
    always_comb begin
        n_data = i_data;
        for (int l = 0; l < 4; l++) begin
            w_trial[l] = {i_data.rem[l], i_data.acc[l][31]};
            if (w_trial[l] >= {1'b0, i_data.den[l]}) begin
                n_data.rem[l] = 10'(w_trial[l] - {1'b0, i_data.den[l]});
                n_data.acc[l] = {i_data.acc[l][30:0], 1'b1};
            end else begin
                n_data.rem[l] = w_trial[l][9:0];
                n_data.acc[l] = {i_data.acc[l][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/usvg_trig_cell.sv
// One step of the sine polynomial for all eight lanes, registered.
// Depends on usvg_pkg for t_trig and the t_trig_op codes.
module usvg_trig_cell
    import usvg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_trig_op    i_op,
    input  logic [30:0] i_coef,
    input  logic        i_valid,
    input  t_trig       i_data,
    output logic        o_valid,
    output t_trig       o_data
);

    logic [7:0][30:0] w_a;
    logic [7:0][30:0] w_b;
    logic [7:0][61:0] w_prod;
    t_trig            n_data;
    logic             r_valid;
    t_trig            r_data;

    always_comb begin
        n_data = i_data;
        for (int l = 0; l < 8; l++) begin
            unique case (i_op)
                OP_SQUARE: begin
                    w_a[l] = i_data.x[l];
                    w_b[l] = i_data.x[l];
                end
                OP_HORNER: begin
                    w_a[l] = i_data.t[l];
                    w_b[l] = i_data.x2[l];
                end
                OP_FINAL: begin
                    w_a[l] = i_data.t[l];
                    w_b[l] = i_data.x[l];
                end
                default: begin
                    w_a[l] = '0;
                    w_b[l] = '0;
                end
            endcase
            w_prod[l] = {31'd0, w_a[l]} * {31'd0, w_b[l]};
            unique case (i_op)
                OP_SQUARE: begin
                    n_data.x2[l] = w_prod[l][60:30];
                    n_data.t[l]  = T_INIT;
                end
                OP_HORNER: n_data.t[l] = i_coef - w_prod[l][60:30];
                OP_FINAL:  n_data.t[l] = w_prod[l][60:30];
                default:   n_data.t[l] = i_data.t[l];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/usvg_vertex_out.sv
// Holds one finished cell and emits its six vertices through an output register.
// Depends on usvg_pkg for t_trig, the vertex order tables and the rounding functions.
module usvg_vertex_out
    import usvg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_trig       i_item,
    output logic        o_take,
    input  logic [15:0] i_red,
    input  logic [15:0] i_green,
    input  logic [15:0] i_blue,
    input  logic [15:0] i_alpha,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [15:0] o_pos_z,
    output logic [15:0] o_out_red,
    output logic [15:0] o_out_green,
    output logic [15:0] o_out_blue,
    output logic [15:0] o_out_alpha,
    output logic [18:0] o_vertex_number,
    output logic        o_bad_cell,
    output logic        o_last_vertex
);

    t_trig       r_item;
    logic        r_busy;
    logic [2:0]  r_k;
    logic        r_out_valid;
    logic [15:0] r_x, r_y, r_z, r_red, r_green, r_blue, r_alpha;
    logic [18:0] r_num;
    logic        r_bad, r_last;

    logic        w_load;
    logic        w_take;
    logic        w_ring, w_dir;
    logic [2:0]  w_rl, w_zl, w_cl, w_sl;
    logic [61:0] w_px, w_py;
    logic [15:0] n_x, n_y, n_z, n_red, n_green, n_blue, n_alpha;
    logic [18:0] n_num;

    assign w_load = r_busy && (!r_out_valid || i_ready);
    assign w_take = !r_busy || (w_load && (r_k == LAST_VERT));
    assign o_take = w_take;

    always_comb begin
        w_ring = RING_OF[r_k];
        w_dir  = DIR_OF[r_k];
        w_rl   = {2'd0, w_ring};
        w_zl   = {2'd1, w_ring};
        w_cl   = {2'd2, w_dir};
        w_sl   = {2'd3, w_dir};
        w_px   = {31'd0, r_item.t[w_rl]} * {31'd0, r_item.t[w_cl]};
        w_py   = {31'd0, r_item.t[w_rl]} * {31'd0, r_item.t[w_sl]};
        if (r_item.bad) begin
            n_x = '0; n_y = '0; n_z = '0;
            n_red = '0; n_green = '0; n_blue = '0; n_alpha = '0;
            n_num = '0;
        end else begin
            n_x = f_coord_xy(w_px, r_item.neg[w_rl] ^ r_item.neg[w_cl]);
            n_y = f_coord_xy(w_py, r_item.neg[w_rl] ^ r_item.neg[w_sl]);
            n_z = f_coord_z(r_item.t[w_zl], r_item.neg[w_zl]);
            n_red   = i_red;
            n_green = i_green;
            n_blue  = i_blue;
            n_alpha = i_alpha;
            n_num   = r_item.base + {16'd0, r_k};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_busy <= i_item_valid;
                r_k    <= '0;
            end else if (w_load) begin
                r_k <= r_k + 3'd1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_item_valid) begin
            r_item <= i_item;
        end
        if (w_load) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_alpha <= n_alpha;
            r_num   <= n_num;
            r_bad   <= r_item.bad;
            r_last  <= (r_k == LAST_VERT);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pos_x         = r_x;
    assign o_pos_y         = r_y;
    assign o_pos_z         = r_z;
    assign o_out_red       = r_red;
    assign o_out_green     = r_green;
    assign o_out_blue      = r_blue;
    assign o_out_alpha     = r_alpha;
    assign o_vertex_number = r_num;
    assign o_bad_cell      = r_bad;
    assign o_last_vertex   = r_last;

endmodule

>>> hw/rtl/uv_sphere_vertex_generator_top.sv
// UV sphere vertex generator: top level with configuration registers and the cell chains.
// Depends on usvg_pkg, usvg_div_cell, usvg_trig_cell and usvg_vertex_out.
//
// Each input transaction names one cell (layer, slice) of a unit UV sphere and
// produces six output transactions, the vertices of the cell's two triangles, each
// carrying Q2.14 coordinates, the configured color, a running vertex number and a
// last marker. A cell that lies outside the configured counts still gives six
// vertices, all zero but for the bad cell flag and the last marker. The output
// stage sets the sustained rate: it hands out one vertex per cycle while i_ready
// is high, and a new cell enters it in the same cycle as the previous cell's last
// vertex is loaded into the output register. Between input and output a cell
// passes one entry stage, a chain of 32 division cells that form the four angle
// phases one quotient bit per cell, a chain of six polynomial cells that evaluate
// the eight sines and cosines, the register that holds the cell in the output
// stage, and the output register.
// The whole chain holds while its last cell waits for the output stage.
// Configuration registers may be written only while no cell is in flight.
module uv_sphere_vertex_generator_top
    import usvg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_layer_index,
    input  logic [7:0]  i_slice_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [15:0] o_pos_z,
    output logic [15:0] o_out_red,
    output logic [15:0] o_out_green,
    output logic [15:0] o_out_blue,
    output logic [15:0] o_out_alpha,
    output logic [18:0] o_vertex_number,
    output logic        o_bad_cell,
    output logic        o_last_vertex
);

    logic [8:0]  r_slice_count;
    logic [8:0]  r_layer_count;
    logic [15:0] r_red, r_green, r_blue, r_alpha;

    // Configuration writes; an index past the last register is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_count <= 9'd16;
            r_layer_count <= 9'd16;
            r_red         <= 16'hFFFF;
            r_green       <= 16'hFFFF;
            r_blue        <= 16'hFFFF;
            r_alpha       <= 16'hFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SLICE_COUNT: r_slice_count <= i_cfg_data[8:0];
                CFG_LAYER_COUNT: r_layer_count <= i_cfg_data[8:0];
                CFG_COLOR_RED:   r_red         <= i_cfg_data;
                CFG_COLOR_GREEN: r_green       <= i_cfg_data;
                CFG_COLOR_BLUE:  r_blue        <= i_cfg_data;
                CFG_COLOR_ALPHA: r_alpha       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The chain moves as a whole whenever its last cell is empty or being taken.
    logic  w_adv;
    logic  w_take;
    logic  w_div_v  [0:DIV_STEPS];
    t_div  w_div    [0:DIV_STEPS];
    logic  w_trig_v [0:TRIG_STEPS];
    t_trig w_trig   [0:TRIG_STEPS];

    assign w_adv   = !w_trig_v[TRIG_STEPS] || w_take;
    assign o_ready = w_adv;

    // Entry stage: range check, vertex number base and the first remainders.
    logic        w_bad;
    logic [20:0] w_base;
    logic [9:0]  w_lden, w_sden;
    logic [3:0][9:0] w_num;
    t_div        n_s0;
    logic        r_s0_valid;
    t_div        r_s0;

    always_comb begin
        w_bad = (r_slice_count == 9'd0) || (r_slice_count > 9'(MAX_DIVISIONS)) ||
                (r_layer_count == 9'd0) || (r_layer_count > 9'(MAX_DIVISIONS)) ||
                ({1'b0, i_layer_index} >= r_layer_count) ||
                ({1'b0, i_slice_index} >= r_slice_count);
        w_base = 21'({13'd0, i_layer_index} * {12'd0, r_slice_count}) +
                 {13'd0, i_slice_index};
        w_base = (w_base << 2) + (w_base << 1);
        w_lden = {r_layer_count, 1'b0};
        w_sden = {1'b0, r_slice_count};
        w_num[0] = {2'd0, i_layer_index};
        w_num[1] = {2'd0, i_layer_index} + 10'd1;
        w_num[2] = {2'd0, i_slice_index};
        w_num[3] = {2'd0, i_slice_index} + 10'd1;
        n_s0.bad  = w_bad;
        n_s0.base = w_base[18:0];
        n_s0.den[0] = w_lden;
        n_s0.den[1] = w_lden;
        n_s0.den[2] = w_sden;
        n_s0.den[3] = w_sden;
        // A phase of a whole turn wraps to zero, so only the remainder of the
        // integer part enters the division.
        for (int l = 0; l < 4; l++) begin
            n_s0.rem[l] = (w_num[l] >= n_s0.den[l]) ? (w_num[l] - n_s0.den[l])
                                                    : w_num[l];
            n_s0.acc[l] = {23'd0, n_s0.den[l][9:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0 <= n_s0;
        end
    end

    assign w_div_v[0] = r_s0_valid;
    assign w_div[0]   = r_s0;

    // Phase division chain: each cell produces one quotient bit of all four phases.
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        usvg_div_cell u_div_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_div_v[g]),
            .i_data  (w_div[g]),
            .o_valid (w_div_v[g+1]),
            .o_data  (w_div[g+1])
        );
    end

    // Fold the phases into quarter-turn arguments for the eight sine lanes.
    t_fold w_fold [0:7];

    always_comb begin
        w_fold[0] = f_fold(w_div[DIV_STEPS].acc[0], 1'b0);
        w_fold[1] = f_fold(w_div[DIV_STEPS].acc[1], 1'b0);
        w_fold[2] = f_fold(w_div[DIV_STEPS].acc[0], 1'b1);
        w_fold[3] = f_fold(w_div[DIV_STEPS].acc[1], 1'b1);
        w_fold[4] = f_fold(w_div[DIV_STEPS].acc[2], 1'b1);
        w_fold[5] = f_fold(w_div[DIV_STEPS].acc[3], 1'b1);
        w_fold[6] = f_fold(w_div[DIV_STEPS].acc[2], 1'b0);
        w_fold[7] = f_fold(w_div[DIV_STEPS].acc[3], 1'b0);
        w_trig[0].bad  = w_div[DIV_STEPS].bad;
        w_trig[0].base = w_div[DIV_STEPS].base;
        w_trig[0].x2   = '0;
        w_trig[0].t    = '0;
        for (int l = 0; l < 8; l++) begin
            w_trig[0].x[l]   = w_fold[l].x;
            w_trig[0].neg[l] = w_fold[l].neg;
        end
        // z is minus the cosine of the polar angle.
        w_trig[0].neg[2] = !w_fold[2].neg;
        w_trig[0].neg[3] = !w_fold[3].neg;
    end

    assign w_trig_v[0] = w_div_v[DIV_STEPS];

    // Polynomial chain: square the argument, four Horner steps, final product.
    for (genvar g = 0; g < TRIG_STEPS; g++) begin : g_trig
        localparam t_trig_op CELL_OP = (g == 0) ? OP_SQUARE :
                                       (g == TRIG_STEPS - 1) ? OP_FINAL : OP_HORNER;
        localparam int COEF_SEL = (g >= 1 && g <= 4) ? g - 1 : 0;
        usvg_trig_cell u_trig_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_op    (CELL_OP),
            .i_coef  (HORNER_COEF[COEF_SEL]),
            .i_valid (w_trig_v[g]),
            .i_data  (w_trig[g]),
            .o_valid (w_trig_v[g+1]),
            .o_data  (w_trig[g+1])
        );
    end

    // Output stage: six vertices per cell, one per cycle while i_ready is high.
    usvg_vertex_out u_vertex_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (w_trig_v[TRIG_STEPS]),
        .i_item          (w_trig[TRIG_STEPS]),
        .o_take          (w_take),
        .i_red           (r_red),
        .i_green         (r_green),
        .i_blue          (r_blue),
        .i_alpha         (r_alpha),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_out_red       (o_out_red),
        .o_out_green     (o_out_green),
        .o_out_blue      (o_out_blue),
        .o_out_alpha     (o_out_alpha),
        .o_vertex_number (o_vertex_number),
        .o_bad_cell      (o_bad_cell),
        .o_last_vertex   (o_last_vertex)
    );

endmodule
